>>> src/resistor_ladder_button_debouncer_unit_macros.svh
// ----------------------------------------------------------------------------
// resistor_ladder_button_debouncer_unit_macros
// Assertion helpers for the keypad debouncer block.
// ----------------------------------------------------------------------------
`ifndef RESISTOR_LADDER_BUTTON_DEBOUNCER_UNIT_MACROS_SVH
`define RESISTOR_LADDER_BUTTON_DEBOUNCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define RLBD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlbd assertion failed: same-cycle check");

// Next-cycle implication, disabled while rst is high.
`define RLBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlbd assertion failed: next-cycle check");

`endif

>>> src/rlbd_pkg.sv
// ----------------------------------------------------------------------------
// rlbd_pkg
// Shared widths, button codes and register indexes of the keypad debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlbd_pkg;

   localparam int ADC_W   = 12;
   localparam int BTN_W   = 3;
   localparam int MATCH_W = 8;
   localparam int ELAP_W  = 16;
   localparam int CSR_W   = 12;
   localparam int NUM_THR = 7;

   localparam logic [BTN_W-1:0] BTN_NONE = 3'b000;
   localparam logic [BTN_W-1:0] BTN_A    = 3'b100;
   localparam logic [BTN_W-1:0] BTN_B    = 3'b010;
   localparam logic [BTN_W-1:0] BTN_C    = 3'b001;

   typedef enum logic [2:0] {
      CSR_THR_NONE  = 3'd0,
      CSR_THR_C     = 3'd1,
      CSR_THR_B     = 3'd2,
      CSR_THR_BC    = 3'd3,
      CSR_THR_A     = 3'd4,
      CSR_THR_AC    = 3'd5,
      CSR_THR_AB    = 3'd6,
      CSR_MATCH_MAX = 3'd7
   } csr_index_type;

   // threshold reset values, in the order of the register indexes
   localparam logic [ADC_W-1:0] THR_NONE_RST = 12'd2760;
   localparam logic [ADC_W-1:0] THR_C_RST    = 12'd2480;
   localparam logic [ADC_W-1:0] THR_B_RST    = 12'd2110;
   localparam logic [ADC_W-1:0] THR_BC_RST   = 12'd1810;
   localparam logic [ADC_W-1:0] THR_A_RST    = 12'd1580;
   localparam logic [ADC_W-1:0] THR_AC_RST   = 12'd1420;
   localparam logic [ADC_W-1:0] THR_AB_RST   = 12'd1290;
   localparam logic [MATCH_W-1:0] MATCH_MAX_RST = 8'd3;

endpackage

`default_nettype wire

>>> src/resistor_ladder_button_debouncer_unit.sv
// ----------------------------------------------------------------------------
// resistor_ladder_button_debouncer_unit
// Decodes a three-button resistor ladder from ADC polls and debounces it.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  req     | in        | req_valid/req_stall| req_adc_mv[11:0], req_ms_tick
//  rsp     | out       | rsp_valid/rsp_stall| rsp_stable_buttons[2:0],
//          |           |                    | rsp_last_sample_mv[11:0]
//  csr     | in        | csr_wr_en          | csr_index[2:0], csr_wdata[11:0]
//
// One poll per cycle while req_stall is low. Each accepted poll updates the
// debounce state in the cycle of its transfer, and its result is registered
// in the output register, or in the skid when that holds an unread result.
// The output register has a one-entry skid behind it: req_stall rises only
// once both hold an unread result, i.e. with back-to-back polls a stalled
// rsp fills the skid and req_stall is high from the next cycle on.
// Reset (synchronous) clears all debounce state and loads the threshold
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module resistor_ladder_button_debouncer_unit #(
   parameter int SAMPLE_INTERVAL_MS = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [rlbd_pkg::ADC_W-1:0]  req_adc_mv,
   input  wire logic                        req_ms_tick,

   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [rlbd_pkg::BTN_W-1:0]       rsp_stable_buttons,
   output logic [rlbd_pkg::ADC_W-1:0]       rsp_last_sample_mv,

   input  wire logic                        csr_wr_en,
   input  wire logic [2:0]                  csr_index,
   input  wire logic [rlbd_pkg::CSR_W-1:0]  csr_wdata
);

   localparam logic [rlbd_pkg::ELAP_W-1:0] INTERVAL =
      rlbd_pkg::ELAP_W'(SAMPLE_INTERVAL_MS);
   localparam logic [rlbd_pkg::ELAP_W-1:0]  ELAP_SAT  = '1;
   localparam logic [rlbd_pkg::MATCH_W-1:0] MATCH_SAT = '1;

   // ---------------------------------------------------------------- config
   logic [rlbd_pkg::ADC_W-1:0]   thr_ff [rlbd_pkg::NUM_THR];
   logic [rlbd_pkg::MATCH_W-1:0] match_max_ff;

   rlbd_pkg::csr_index_type csr_sel;
   assign csr_sel = rlbd_pkg::csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff[rlbd_pkg::CSR_THR_NONE] <= rlbd_pkg::THR_NONE_RST;
         thr_ff[rlbd_pkg::CSR_THR_C]    <= rlbd_pkg::THR_C_RST;
         thr_ff[rlbd_pkg::CSR_THR_B]    <= rlbd_pkg::THR_B_RST;
         thr_ff[rlbd_pkg::CSR_THR_BC]   <= rlbd_pkg::THR_BC_RST;
         thr_ff[rlbd_pkg::CSR_THR_A]    <= rlbd_pkg::THR_A_RST;
         thr_ff[rlbd_pkg::CSR_THR_AC]   <= rlbd_pkg::THR_AC_RST;
         thr_ff[rlbd_pkg::CSR_THR_AB]   <= rlbd_pkg::THR_AB_RST;
         match_max_ff <= rlbd_pkg::MATCH_MAX_RST;
      end else if (csr_wr_en) begin
         unique case (csr_sel)
            rlbd_pkg::CSR_THR_NONE:  thr_ff[rlbd_pkg::CSR_THR_NONE] <= csr_wdata;
            rlbd_pkg::CSR_THR_C:     thr_ff[rlbd_pkg::CSR_THR_C]    <= csr_wdata;
            rlbd_pkg::CSR_THR_B:     thr_ff[rlbd_pkg::CSR_THR_B]    <= csr_wdata;
            rlbd_pkg::CSR_THR_BC:    thr_ff[rlbd_pkg::CSR_THR_BC]   <= csr_wdata;
            rlbd_pkg::CSR_THR_A:     thr_ff[rlbd_pkg::CSR_THR_A]    <= csr_wdata;
            rlbd_pkg::CSR_THR_AC:    thr_ff[rlbd_pkg::CSR_THR_AC]   <= csr_wdata;
            rlbd_pkg::CSR_THR_AB:    thr_ff[rlbd_pkg::CSR_THR_AB]   <= csr_wdata;
            rlbd_pkg::CSR_MATCH_MAX: match_max_ff <= csr_wdata[rlbd_pkg::MATCH_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------- debounce state
   logic [rlbd_pkg::ELAP_W-1:0]  elapsed_ff, elapsed_in;
   logic [rlbd_pkg::BTN_W-1:0]   cand_ff, cand_in;
   logic [rlbd_pkg::MATCH_W-1:0] match_ff, match_in;
   logic [rlbd_pkg::BTN_W-1:0]   stable_ff, stable_in;
   logic [rlbd_pkg::ADC_W-1:0]   sample_ff, sample_in;

   logic                         req_xfer;
   logic [rlbd_pkg::ELAP_W-1:0]  elapsed_tick;
   logic                         sample_now;
   logic [rlbd_pkg::BTN_W-1:0]   btn_class;
   logic [rlbd_pkg::MATCH_W-1:0] match_step;

   assign req_xfer = req_valid && !req_stall;

   // ladder decode: first threshold strictly exceeded wins, top down
   always_comb begin
      priority if (req_adc_mv > thr_ff[rlbd_pkg::CSR_THR_NONE])
         btn_class = rlbd_pkg::BTN_NONE;
      else if (req_adc_mv > thr_ff[rlbd_pkg::CSR_THR_C])
         btn_class = rlbd_pkg::BTN_C;
      else if (req_adc_mv > thr_ff[rlbd_pkg::CSR_THR_B])
         btn_class = rlbd_pkg::BTN_B;
      else if (req_adc_mv > thr_ff[rlbd_pkg::CSR_THR_BC])
         btn_class = rlbd_pkg::BTN_B | rlbd_pkg::BTN_C;
      else if (req_adc_mv > thr_ff[rlbd_pkg::CSR_THR_A])
         btn_class = rlbd_pkg::BTN_A;
      else if (req_adc_mv > thr_ff[rlbd_pkg::CSR_THR_AC])
         btn_class = rlbd_pkg::BTN_A | rlbd_pkg::BTN_C;
      else if (req_adc_mv > thr_ff[rlbd_pkg::CSR_THR_AB])
         btn_class = rlbd_pkg::BTN_A | rlbd_pkg::BTN_B;
      else
         btn_class = rlbd_pkg::BTN_A | rlbd_pkg::BTN_B | rlbd_pkg::BTN_C;
   end

   always_comb begin
      elapsed_tick = (req_ms_tick && elapsed_ff != ELAP_SAT) ?
                     elapsed_ff + 1'b1 : elapsed_ff;
      sample_now   = elapsed_tick > INTERVAL;

      // repeat count after this sample, before the accept check
      if (btn_class == cand_ff)
         match_step = (match_ff != MATCH_SAT) ? match_ff + 1'b1 : match_ff;
      else
         match_step = '0;

      elapsed_in = elapsed_ff;
      cand_in    = cand_ff;
      match_in   = match_ff;
      stable_in  = stable_ff;
      sample_in  = sample_ff;

      if (req_xfer) begin
         elapsed_in = elapsed_tick;
         if (sample_now) begin
            elapsed_in = '0;
            sample_in  = req_adc_mv;
            cand_in    = btn_class;
            match_in   = match_step;
            // zero limit accepts every sample at once
            if (match_step >= match_max_ff) begin
               stable_in = btn_class;
               match_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         cand_ff    <= rlbd_pkg::BTN_NONE;
         match_ff   <= '0;
         stable_ff  <= rlbd_pkg::BTN_NONE;
         sample_ff  <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
         cand_ff    <= cand_in;
         match_ff   <= match_in;
         stable_ff  <= stable_in;
         sample_ff  <= sample_in;
      end
   end

   // ------------------------------------------------ output reg + skid
   logic                       out_valid_ff, skid_valid_ff;
   logic [rlbd_pkg::BTN_W-1:0] out_btn_ff, skid_btn_ff;
   logic [rlbd_pkg::ADC_W-1:0] out_mv_ff, skid_mv_ff;
   logic                       rsp_xfer;

   assign rsp_xfer  = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // input is held off; drain skid into the output register
         if (rsp_xfer) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_xfer) begin
         if (!out_valid_ff || rsp_xfer)
            out_valid_ff <= 1'b1;
         else
            skid_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         out_valid_ff <= 1'b0;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_xfer) begin
            out_btn_ff <= skid_btn_ff;
            out_mv_ff  <= skid_mv_ff;
         end
      end else if (req_xfer) begin
         if (!out_valid_ff || rsp_xfer) begin
            out_btn_ff <= stable_in;
            out_mv_ff  <= sample_in;
         end else begin
            skid_btn_ff <= stable_in;
            skid_mv_ff  <= sample_in;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_stable_buttons = out_btn_ff;
   assign rsp_last_sample_mv = out_mv_ff;

endmodule

`default_nettype wire

>>> src/rlbd_checker.sv
// ----------------------------------------------------------------------------
// rlbd_checker
// Port-level checks of the keypad debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "resistor_ladder_button_debouncer_unit_macros.svh"

module rlbd_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [rlbd_pkg::BTN_W-1:0] rsp_stable_buttons,
   input wire logic [rlbd_pkg::ADC_W-1:0] rsp_last_sample_mv
);

   logic                                      rsp_wait;
   logic [rlbd_pkg::BTN_W+rlbd_pkg::ADC_W-1:0] rsp_data;

   assign rsp_wait = rsp_valid && rsp_stall;
   assign rsp_data = {rsp_stable_buttons, rsp_last_sample_mv};

   // nothing left over from before reset
   `RLBD_ASSERT_NEXT(a_rst_empty, clock, 1'b0, reset, !rsp_valid && !req_stall)

   // a transfer in always leaves a result on rsp next cycle
   `RLBD_ASSERT_NEXT(a_xfer_to_rsp, clock, reset, req_valid && !req_stall, rsp_valid)

   // input backs up only when a result is already waiting
   `RLBD_ASSERT_SAME(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid)

   // stalled result holds
   `RLBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_data))

endmodule

bind resistor_ladder_button_debouncer_unit rlbd_checker u_rlbd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_stable_buttons (rsp_stable_buttons),
   .rsp_last_sample_mv (rsp_last_sample_mv)
);

`default_nettype wire

>>> test/tb_resistor_ladder_button_debouncer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resistor_ladder_button_debouncer_unit
// Self-checking bench for the resistor-ladder keypad decoder and debouncer.
// A directed table opens the run. Then come phases of random polls under
// several threshold and debounce settings. Each poll transfer is run through
// a local debounce predictor. Each rsp transfer is checked field by field
// against the oldest predicted result. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_resistor_ladder_button_debouncer_unit;

   localparam int SAMPLE_MS   = 10;      // elapsed count must exceed this
   localparam int CYCLE_LIMIT = 500000;  // far above the slowest legal run
   localparam int MAX_REPORTS = 10;
   localparam int JUNK_W      = rlbd_pkg::CSR_W - rlbd_pkg::MATCH_W;

   // one result: debounced set plus held sample
   typedef struct packed {
      logic [rlbd_pkg::BTN_W-1:0] buttons;
      logic [rlbd_pkg::ADC_W-1:0] sample;
   } poll_result_type;

   // a directed row; checked rows carry a hand-typed result
   typedef struct {
      logic [rlbd_pkg::ADC_W-1:0] adc;
      logic                       tick;
      bit                         checked;
      logic [rlbd_pkg::BTN_W-1:0] btn;
      logic [rlbd_pkg::ADC_W-1:0] smp;
   } stim_row_type;

   // ---------------------------------------------------------------------
   // DUT hookup; every input is known from time zero
   // ---------------------------------------------------------------------
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [rlbd_pkg::ADC_W-1:0]   req_adc_mv = '0;
   logic                         req_ms_tick = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [rlbd_pkg::BTN_W-1:0]   rsp_stable_buttons;
   logic [rlbd_pkg::ADC_W-1:0]   rsp_last_sample_mv;
   logic                         csr_wr_en = 1'b0;
   logic [2:0]                   csr_index = '0;
   logic [rlbd_pkg::CSR_W-1:0]   csr_wdata = '0;

   resistor_ladder_button_debouncer_unit #(
      .SAMPLE_INTERVAL_MS(SAMPLE_MS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_adc_mv         (req_adc_mv),
      .req_ms_tick        (req_ms_tick),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stable_buttons (rsp_stable_buttons),
      .rsp_last_sample_mv (rsp_last_sample_mv),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Debounce predictor: own copy of the registers and the state
   // ---------------------------------------------------------------------
   logic [rlbd_pkg::ADC_W-1:0]   cfg_thr [rlbd_pkg::NUM_THR] = '{
      rlbd_pkg::THR_NONE_RST, rlbd_pkg::THR_C_RST, rlbd_pkg::THR_B_RST,
      rlbd_pkg::THR_BC_RST, rlbd_pkg::THR_A_RST, rlbd_pkg::THR_AC_RST,
      rlbd_pkg::THR_AB_RST};
   logic [rlbd_pkg::MATCH_W-1:0] cfg_match_max = rlbd_pkg::MATCH_MAX_RST;

   logic [rlbd_pkg::ELAP_W-1:0]  elapsed_ms = '0;
   logic [rlbd_pkg::BTN_W-1:0]   cand_set   = rlbd_pkg::BTN_NONE;
   logic [rlbd_pkg::MATCH_W-1:0] match_run  = '0;
   logic [rlbd_pkg::BTN_W-1:0]   stable_set = rlbd_pkg::BTN_NONE;
   logic [rlbd_pkg::ADC_W-1:0]   held_mv    = '0;

   // sets in ladder order, from the top threshold down
   logic [rlbd_pkg::BTN_W-1:0]   ladder_set [rlbd_pkg::NUM_THR] = '{
      rlbd_pkg::BTN_NONE, rlbd_pkg::BTN_C, rlbd_pkg::BTN_B,
      rlbd_pkg::BTN_B | rlbd_pkg::BTN_C, rlbd_pkg::BTN_A,
      rlbd_pkg::BTN_A | rlbd_pkg::BTN_C, rlbd_pkg::BTN_A | rlbd_pkg::BTN_B};

   poll_result_type    expected_polls [$];
   int                 mismatch_count = 0;
   int                 cycle_count    = 0;

   // First threshold the reading strictly exceeds wins, so an unordered
   // ladder still has a defined answer. Below all of them: all three.
   function automatic logic [rlbd_pkg::BTN_W-1:0] classify_mv(
      input logic [rlbd_pkg::ADC_W-1:0] mv);
      for (int i = 0; i < rlbd_pkg::NUM_THR; i++)
         if (mv > cfg_thr[i]) return ladder_set[i];
      return rlbd_pkg::BTN_A | rlbd_pkg::BTN_B | rlbd_pkg::BTN_C;
   endfunction

   task automatic debounce_poll(input logic [rlbd_pkg::ADC_W-1:0] mv, input logic tick,
                                output poll_result_type r);
      logic [rlbd_pkg::BTN_W-1:0] set;
      if (tick && elapsed_ms != '1)
         elapsed_ms++;
      if (elapsed_ms > SAMPLE_MS) begin
         elapsed_ms = '0;
         held_mv    = mv;
         set        = classify_mv(mv);
         if (set == cand_set) begin
            if (match_run != '1) match_run++;   // saturates
         end else begin
            match_run = '0;
            cand_set  = set;
         end
         // a zero limit takes every sample at once
         if (match_run >= cfg_match_max) begin
            stable_set = set;
            match_run  = '0;
         end
      end
      r.buttons = stable_set;
      r.sample  = held_mv;
   endtask

   // ---------------------------------------------------------------------
   // Idle patterns: mostly short gaps, a few long, with gap-free stretches
   // ---------------------------------------------------------------------
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   int stall_left = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int clamp_mv(input int v);
      if (v < 0) return 0;
      if (v > 4095) return 4095;
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Drives one poll and holds it until the transfer, then predicts it.
   task automatic send_poll(input logic [rlbd_pkg::ADC_W-1:0] adc, input logic tick,
                            input bit checked, input poll_result_type typed);
      int              gap;
      poll_result_type pred;
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_adc_mv  <= adc;
      req_ms_tick <= tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // transfer happened at this edge
      debounce_poll(adc, tick, pred);
      expected_polls.push_back(checked ? typed : pred);
   endtask

   // Lower valid and wait until every predicted result has come back.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_polls.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);   // a little margin after the drain
   endtask

   // ---------------------------------------------------------------------
   // Register writes, only while the block is drained
   // ---------------------------------------------------------------------
   logic [rlbd_pkg::ADC_W-1:0] plan_thr [rlbd_pkg::NUM_THR];

   task automatic write_reg(input rlbd_pkg::csr_index_type idx,
                            input logic [rlbd_pkg::CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == rlbd_pkg::CSR_MATCH_MAX) cfg_match_max = data[rlbd_pkg::MATCH_W-1:0];
      else                                cfg_thr[int'(idx)] = data;
   endtask

   // All seven thresholds from plan_thr, then the match limit. Upper data
   // bits of the limit write are junk on purpose: only the low byte counts.
   task automatic apply_setting(input logic [rlbd_pkg::MATCH_W-1:0] mmax);
      logic [JUNK_W-1:0] junk;
      junk = JUNK_W'($urandom_range(0, 15));
      for (int i = 0; i < rlbd_pkg::NUM_THR; i++)
         write_reg(rlbd_pkg::csr_index_type'(i), plan_thr[i]);
      write_reg(rlbd_pkg::CSR_MATCH_MAX, {junk, mmax});
      csr_wr_en <= 1'b0;
   endtask

   task automatic plan_defaults();
      plan_thr = '{rlbd_pkg::THR_NONE_RST, rlbd_pkg::THR_C_RST, rlbd_pkg::THR_B_RST,
                   rlbd_pkg::THR_BC_RST, rlbd_pkg::THR_A_RST, rlbd_pkg::THR_AC_RST,
                   rlbd_pkg::THR_AB_RST};
   endtask

   // ---------------------------------------------------------------------
   // Random polls: a button level held for a few sample periods with small
   // jitter, plus the odd full-range glitch and missing ms ticks. Levels
   // sit near thresholds often so jitter flips the class.
   // ---------------------------------------------------------------------
   function automatic int pick_level();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return clamp_mv(int'(cfg_thr[$urandom_range(0, rlbd_pkg::NUM_THR-1)])
                         + $urandom_range(0, 6) - 3);
      if (r < 55) return $urandom_range(0, 1) ? 4095 : 0;
      return $urandom_range(0, 4095);
   endfunction

   task automatic run_polls(input int n_items, input int drain_at);
      int  sent;
      int  level;
      int  seg_left;
      int  v;
      logic tick;
      sent = 0;
      while (sent < n_items) begin
         level    = pick_level();
         seg_left = (SAMPLE_MS + 1) * $urandom_range(1, 6) + $urandom_range(0, 10);
         while (seg_left > 0 && sent < n_items) begin
            if ($urandom_range(0, 99) < 6) v = $urandom_range(0, 4095);
            else                           v = clamp_mv(level + $urandom_range(0, 4) - 2);
            tick = ($urandom_range(0, 99) < 88);
            send_poll(rlbd_pkg::ADC_W'(v), tick, 1'b0, '0);
            sent++;
            seg_left--;
            // sender holds off once until everything in flight is back
            if (sent == drain_at) wait_drain();
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Directed table, run under reset settings. After reset nothing is
   // sampled until the eleventh ms tick; the held sample is zero till then.
   // Thresholds are strict: a reading equal to one falls to the next set.
   // ---------------------------------------------------------------------
   stim_row_type directed_tbl [25] = '{
      '{12'd4095, 1'b0, 1'b1, rlbd_pkg::BTN_NONE, 12'd0},     // no tick, nothing moves
      '{12'd0,    1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd0},     // elapsed 1
      '{12'd4095, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd0},
      '{12'd0,    1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd0},
      '{12'd4095, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd0},
      '{12'd0,    1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd0},
      '{12'd4095, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd0},
      '{12'd0,    1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd0},
      '{12'd4095, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd0},
      '{12'd0,    1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd0},
      '{12'd4095, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd0},     // elapsed 10, still none
      '{12'd4095, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd4095},  // first sample taken
      '{12'd0,    1'b0, 1'b1, rlbd_pkg::BTN_NONE, 12'd4095},
      '{12'd2760, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd4095},
      '{12'd2761, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd4095},
      '{12'd2480, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd4095},
      '{12'd2110, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd4095},
      '{12'd1810, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd4095},
      '{12'd1580, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd4095},
      '{12'd1420, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd4095},
      '{12'd1290, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd4095},
      '{12'd1289, 1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd4095},
      '{12'd0,    1'b1, 1'b1, rlbd_pkg::BTN_NONE, 12'd4095},  // elapsed 10 again
      '{12'd2760, 1'b1, 1'b0, rlbd_pkg::BTN_NONE, 12'd0},     // sample on the boundary
      '{12'd4095, 1'b0, 1'b0, rlbd_pkg::BTN_NONE, 12'd0}
   };

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int v;
      poll_result_type typed;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_tbl[i]) begin
         typed.buttons = directed_tbl[i].btn;
         typed.sample  = directed_tbl[i].smp;
         send_poll(directed_tbl[i].adc, directed_tbl[i].tick,
                   directed_tbl[i].checked, typed);
      end

      // reset ladder, debounce limit of one
      wait_drain();
      plan_defaults();
      apply_setting(8'd1);
      run_polls(150, 0);

      // random descending ladder
      wait_drain();
      v = 4095;
      for (int i = 0; i < rlbd_pkg::NUM_THR; i++) begin
         v = clamp_mv(v - $urandom_range(40, 560));
         plan_thr[i] = rlbd_pkg::ADC_W'(v);
      end
      apply_setting(8'd2);
      run_polls(150, 0);

      // all thresholds at the floor, zero limit: each sample goes stable
      wait_drain();
      foreach (plan_thr[i]) plan_thr[i] = '0;
      apply_setting(8'd0);
      run_polls(80, 0);

      // all thresholds at the top, longest debounce
      wait_drain();
      foreach (plan_thr[i]) plan_thr[i] = 12'hFFF;
      apply_setting(8'd255);
      run_polls(60, 0);

      // unordered ladder: first exceeded compare wins
      wait_drain();
      foreach (plan_thr[i]) plan_thr[i] = rlbd_pkg::ADC_W'($urandom_range(0, 4095));
      apply_setting(rlbd_pkg::MATCH_W'($urandom_range(1, 5)));
      run_polls(150, 0);

      // back to reset values; mid-phase the sender drains once
      wait_drain();
      plan_defaults();
      apply_setting(rlbd_pkg::MATCH_MAX_RST);
      run_polls(360, 180);

      wait_drain();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && expected_polls.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: random stall, and check of every rsp transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      poll_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_polls.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: buttons %0d sample %0d",
                        rsp_stable_buttons, rsp_last_sample_mv);
         end else begin
            want = expected_polls.pop_front();
            if (rsp_stable_buttons !== want.buttons ||
                rsp_last_sample_mv !== want.sample) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: buttons exp %0d got %0d, sample exp %0d got %0d",
                           want.buttons, rsp_stable_buttons,
                           want.sample, rsp_last_sample_mv);
            end
         end
      end
      if ($urandom_range(0, 79) == 0) rsp_burst = !rsp_burst;
      if (stall_left == 0 && !rsp_burst && $urandom_range(0, 99) < 25)
         stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                   : $urandom_range(8, 40);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

>>> resistor_ladder_button_debouncer_unit.f
+incdir+src
src/rlbd_pkg.sv
src/resistor_ladder_button_debouncer_unit.sv
src/rlbd_checker.sv
test/tb_resistor_ladder_button_debouncer_unit.sv
